// File: src/dgs_pkg.sv
// Package: shared types, codes and constants of the diagonal Gaussian scorer.
`default_nettype none
package dgs_pkg;

    localparam int VEC_LEN_DEF       = 64;
    localparam int MAX_DENSITIES_DEF = 1024;

    localparam int CMD_W   = 2;
    localparam int DIM_W   = 6;
    localparam int VAL_W   = 16;
    localparam int IVAR_W  = 16;
    localparam int GC_W    = 32;
    localparam int SCORE_W = 32;
    localparam int DIDX_W  = 10;
    localparam int ACC_W   = 48;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int PROD_W  = SQ_W + IVAR_W;
    localparam int TERM_W  = PROD_W - 12 + 1;

    localparam logic [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W+1)'(2048);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ELEM   = 2'd1,
        CMD_ABSENT = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_PROD,
        S_TERM,
        S_ACC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic calc_diff;
        logic calc_sq;
        logic calc_prod;
        logic calc_term;
        logic calc_acc;
        logic emit;
    } dgs_ctl_t;

    typedef struct packed {
        logic     in_valid;
        command_t in_cmd;
        logic     last;
        logic     out_busy;
    } dgs_stat_t;

endpackage
`default_nettype wire

// File: src/dgs_in_if.sv
// Interface: input word channel (observation loads and density elements).
`default_nettype none
interface dgs_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [5:0]           dim_index;
    logic signed [15:0]   value;
    logic [15:0]          inv_var;
    logic signed [31:0]   gconst;
    logic                 first;
    logic                 last;

    modport source (output valid, command, dim_index, value, inv_var, gconst, first, last,
                    input ready);
    modport sink   (input valid, command, dim_index, value, inv_var, gconst, first, last,
                    output ready);
endinterface
`default_nettype wire

// File: src/dgs_out_if.sv
// Interface: result word channel (score and density index).
`default_nettype none
interface dgs_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   score;
    logic [9:0]           density_index;

    modport source (output valid, score, density_index, input ready);
    modport sink   (input valid, score, density_index, output ready);
endinterface
`default_nettype wire

// File: src/dgs_ctrl.sv
// Controller: sequences one input word at a time through the datapath steps.
`default_nettype none
module dgs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dgs_pkg::dgs_stat_t stat,
    output dgs_pkg::dgs_ctl_t      ctl
);
    import dgs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.take = 1'b1;
                if (stat.in_valid)
                begin
                    case (stat.in_cmd)
                        CMD_ELEM:   state_next = S_DIFF;
                        CMD_ABSENT: state_next = S_EMIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_DIFF:
            begin
                ctl.calc_diff = 1'b1;
                state_next    = S_SQ;
            end
            S_SQ:
            begin
                ctl.calc_sq = 1'b1;
                state_next  = S_PROD;
            end
            S_PROD:
            begin
                ctl.calc_prod = 1'b1;
                state_next    = S_TERM;
            end
            S_TERM:
            begin
                ctl.calc_term = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                ctl.calc_acc = 1'b1;
                state_next   = stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                // hold until the result register can take a new word
                if (!stat.out_busy)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/dgs_datapath.sv
// Datapath: observation memory, difference/square/multiply steps, accumulator, result register.
`default_nettype none
module dgs_datapath #(
    parameter int VEC_LEN       = dgs_pkg::VEC_LEN_DEF,
    parameter int MAX_DENSITIES = dgs_pkg::MAX_DENSITIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    dgs_in_if.sink                  elem,
    dgs_out_if.source               result,
    input  wire dgs_pkg::dgs_ctl_t  ctl,
    output dgs_pkg::dgs_stat_t      stat
);
    import dgs_pkg::*;

    localparam int AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
    localparam int CW = (MAX_DENSITIES > 1) ? $clog2(MAX_DENSITIES) : 1;

    logic [VAL_W-1:0]   obs_mem_reg [VEC_LEN];

    logic               accept;
    logic [31:0]        dim_wide;
    logic [AW-1:0]      addr;
    logic               dim_ok;

    // latched word
    command_t           cmd_reg;
    logic               dim_ok_reg;
    logic [VAL_W-1:0]   obs_rd_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IVAR_W-1:0]  ivar_reg;
    logic [GC_W-1:0]    gconst_reg;
    logic               first_reg;
    logic               last_reg;

    logic [VAL_W-1:0]   obs_sel;
    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]     diff_abs;
    logic [MAG_W-1:0]   mag_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W:0]    prod_round;
    logic [TERM_W-1:0]  term_reg;

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_base;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_next;

    logic signed [ACC_W:0] acc_neg;
    logic signed [ACC_W:0] half_neg;
    logic [SCORE_W-1:0] score_sat;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [31:0]        count_wide;

    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic [DIDX_W-1:0]  out_index_reg;

    assign elem.ready = ctl.take;
    assign accept     = elem.valid && ctl.take;

    assign dim_wide = 32'(elem.dim_index);
    assign addr     = dim_wide[AW-1:0];
    assign dim_ok   = (dim_wide < 32'(VEC_LEN));

    assign stat.in_valid = elem.valid;
    assign stat.in_cmd   = command_t'(elem.command);
    assign stat.last     = last_reg;
    assign stat.out_busy = out_valid_reg && !result.ready;

    // memory: write on load, registered read on every accepted word
    always_ff @(posedge clk)
    begin
        if (accept && (command_t'(elem.command) == CMD_LOAD) && dim_ok)
        begin
            obs_mem_reg[addr] <= elem.value;
        end
        if (accept)
        begin
            obs_rd_reg <= obs_mem_reg[addr];
        end
    end

    // arithmetic
    assign obs_sel    = dim_ok_reg ? obs_rd_reg : '0;
    assign diff       = $signed({obs_sel[VAL_W-1], obs_sel}) - $signed({val_reg[VAL_W-1], val_reg});
    assign diff_abs   = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
    assign prod_round = {1'b0, prod_reg} + ROUND_HALF;

    assign acc_base = first_reg ? {{(ACC_W-GC_W){gconst_reg[GC_W-1]}}, gconst_reg} : acc_reg;
    assign acc_sum  = {acc_base[ACC_W-1], acc_base} + (ACC_W+1)'(term_reg);
    // term is never negative, so only the upper bound can be crossed
    assign acc_next = (!acc_sum[ACC_W] && acc_sum[ACC_W-1]) ? ACC_MAX : acc_sum[ACC_W-1:0];

    // floor(-acc/2) saturated to 32 bits
    assign acc_neg  = -$signed({acc_reg[ACC_W-1], acc_reg});
    assign half_neg = acc_neg >>> 1;
    always_comb
    begin
        if (!half_neg[ACC_W] && (half_neg[ACC_W-1:SCORE_W-1] != '0))
        begin
            score_sat = SCORE_MAX;
        end
        else if (half_neg[ACC_W] && (half_neg[ACC_W-1:SCORE_W-1] != '1))
        begin
            score_sat = SCORE_MIN;
        end
        else
        begin
            score_sat = half_neg[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command_t'(elem.command);
            dim_ok_reg <= dim_ok;
            val_reg    <= elem.value;
            ivar_reg   <= elem.inv_var;
            gconst_reg <= elem.gconst;
            first_reg  <= elem.first;
            last_reg   <= elem.last;
        end
        if (ctl.calc_diff)
        begin
            mag_reg <= diff_abs[MAG_W-1:0];
        end
        if (ctl.calc_sq)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (ctl.calc_prod)
        begin
            prod_reg <= sq_reg * PROD_W'(ivar_reg);
        end
        if (ctl.calc_term)
        begin
            term_reg <= prod_round[PROD_W:12];
        end
        if (ctl.emit)
        begin
            out_score_reg <= (cmd_reg == CMD_ABSENT) ? SCORE_MIN : score_sat;
            out_index_reg <= count_wide[DIDX_W-1:0];
        end
    end

    assign count_wide = 32'(count_reg);
    assign count_next = (count_wide == 32'(MAX_DENSITIES - 1)) ? '0 : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.calc_acc)
            begin
                acc_reg <= acc_next;
            end
            if (accept && (command_t'(elem.command) == CMD_LOAD))
            begin
                count_reg <= '0;
            end
            else if (ctl.emit)
            begin
                count_reg <= count_next;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.score         = out_score_reg;
    assign result.density_index = out_index_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while pending");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid_reg)
        else $error("emitted word not presented");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (elem.command == CMD_LOAD)) |=> (count_reg == '0))
        else $error("density index not restarted by load");

    a_absent_min: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && (cmd_reg == CMD_ABSENT)) |=> (out_score_reg == SCORE_MIN))
        else $error("absent density did not score minimum");

endmodule
`default_nettype wire

// File: src/diagonal_gaussian_scorer.sv
// Top level: diagonal-covariance Gaussian log-likelihood scorer.
//
// Channels: elem (sink) takes one word per handshake: a command with
// dim_index, value, inv_var, gconst, first and last. result (source)
// gives one word per scored density: score (Q16) and density_index.
// A load word writes one observation element and restarts the density
// index. A density element with first seeds the accumulator with gconst;
// every element adds the rounded (obs-mean)^2*inv_var, and a last element
// sends floor(-acc/2), saturated. An absent density sends the most
// negative score. Command 3 is taken and ignored.
// Words are taken one at a time: a load or ignored word alone, an absent
// density with an emit step, a density element through the difference,
// square, inverse-variance multiply, rounding and accumulate steps of the
// single datapath (and emit with last). Result valid is registered at the
// emit step, reached after ACC for a last element and directly for an absent one.
// A stalled receiver holds the result register; the next word is still
// taken, and the block waits only when its own result is due and the
// register is full. Reset clears accumulator, density index and the
// result valid; the observation memory holds garbage until loaded.
`default_nettype none
module diagonal_gaussian_scorer #(
    parameter int VEC_LEN       = dgs_pkg::VEC_LEN_DEF,
    parameter int MAX_DENSITIES = dgs_pkg::MAX_DENSITIES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dgs_in_if.sink    elem,
    dgs_out_if.source result
);
    import dgs_pkg::*;

    // command and status between sequencer and datapath
    dgs_ctl_t  ctl;
    dgs_stat_t stat;

    dgs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    dgs_datapath #(
        .VEC_LEN       (VEC_LEN),
        .MAX_DENSITIES (MAX_DENSITIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem),
        .result (result),
        .ctl    (ctl),
        .stat   (stat)
    );

endmodule
`default_nettype wire
